>>> rtl/core/apq_pkg.sv
package apq_pkg;

  // queue geometry
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // item codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STS_ENQ   = 2'd0,
    STS_DEQ   = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] prio;
  } entry_t;

  // one input item
  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic [15:0] prio;
  } item_t;

  // store access for one cycle
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  // result handed to the output register
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] value;
    logic [15:0] prio;
  } result_t;

endpackage

>>> rtl/core/apq_store.sv
module apq_store (
  input  logic              clk,
  input  apq_pkg::mem_req_t req,
  output apq_pkg::entry_t   rd_data
);
  import apq_pkg::*;

  entry_t mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/core/apq_ctrl.sv
module apq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  apq_pkg::item_t    item,
  input  apq_pkg::entry_t   rd_data,
  output apq_pkg::mem_req_t req,
  output apq_pkg::result_t  res,
  output logic              busy
);
  import apq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] didx, didx_next;
  logic [IDX_W-1:0] widx, widx_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  entry_t           best, best_next;

  // shared compare unit: first candidate, or a new one that beats the running best
  logic             take;
  logic [IDX_W-1:0] bidx_n;
  entry_t           best_n;

  always_comb begin
    take   = (didx == '0) || ($signed(rd_data.prio) > $signed(best.prio));
    bidx_n = take ? didx : best_idx;
    best_n = take ? rd_data : best;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    didx_next     = didx;
    widx_next     = widx;
    best_idx_next = best_idx;
    best_next     = best;
    req           = '0;
    res           = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.mode == MODE_ENQ) begin
            res.valid = 1'b1;
            if (cnt == CNT_W'(DEPTH)) begin
              res.status = STS_FULL;
            end else begin
              req.wr_en         = 1'b1;
              req.wr_addr       = cnt[IDX_W-1:0];
              req.wr_data.value = item.value;
              req.wr_data.prio  = item.prio;
              cnt_next          = cnt + CNT_W'(1);
              res.status        = STS_ENQ;
            end
          end else if (cnt == '0) begin
            res.valid  = 1'b1;
            res.status = STS_EMPTY;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            didx_next   = '0;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_next     = best_n;
        best_idx_next = bidx_n;
        if ((CNT_W'(didx) + CNT_W'(1)) < cnt) begin
          req.rd_en   = 1'b1;
          req.rd_addr = didx + IDX_W'(1);
          didx_next   = didx + IDX_W'(1);
        end else if ((CNT_W'(bidx_n) + CNT_W'(1)) < cnt) begin
          // close the gap behind the winner
          req.rd_en   = 1'b1;
          req.rd_addr = bidx_n + IDX_W'(1);
          widx_next   = bidx_n;
          state_next  = S_SHIFT;
        end else begin
          res.valid  = 1'b1;
          res.status = STS_DEQ;
          res.value  = best_n.value;
          res.prio   = best_n.prio;
          cnt_next   = cnt - CNT_W'(1);
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = widx;
        req.wr_data = rd_data;
        if ((CNT_W'(widx) + CNT_W'(2)) < cnt) begin
          req.rd_en   = 1'b1;
          req.rd_addr = widx + IDX_W'(2);
          widx_next   = widx + IDX_W'(1);
        end else begin
          res.valid  = 1'b1;
          res.status = STS_DEQ;
          res.value  = best.value;
          res.prio   = best.prio;
          cnt_next   = cnt - CNT_W'(1);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    didx     <= didx_next;
    widx     <= widx_next;
    best_idx <= best_idx_next;
    best     <= best_next;
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (state == S_IDLE))
    else $error("sequencer not idle after result");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> ((CNT_W'(widx) + CNT_W'(1)) < cnt))
    else $error("shift writes outside held entries");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == STS_DEQ) |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("dequeue did not drop the count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept)
    else $error("item taken while sequencer busy");
`endif

endmodule

>>> rtl/core/array_priority_queue.sv
// Bounded priority queue of apq_pkg::DEPTH entries, held unsorted in arrival order.
// Input channel (in_valid / in_stall) carries mode, value and priority_req;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// Mode 0 appends the entry or answers full; mode 1 returns the entry with the
// largest signed priority (earliest on ties) and closes the gap, or answers
// empty. Every item gives exactly one result on the output channel
// (out_valid / out_stall): status, out_value, out_priority.
// Enqueue and reject results are shown the cycle after the transfer.
// A dequeue scans all held entries through the single store read port and
// compare unit, then shifts each entry behind the winner down one place; the
// result is shown the cycle after the last step. in_stall is high while the
// sequencer works. The output register holds one result; while out_stall
// holds it, in_stall stays high, so nothing is lost. Synchronous reset empties
// the queue and the output register; no clearing pass is run over the store.
module array_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] value,
  input  logic signed [15:0] priority_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] out_value,
  output logic signed [15:0] out_priority
);
  import apq_pkg::*;

  item_t    item;
  mem_req_t req;
  entry_t   rd_data;
  result_t  res;
  logic     busy;
  logic     accept;

  // input transfer
  assign in_stall   = busy || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign item.mode  = mode;
  assign item.value = value;
  assign item.prio  = priority_req;

  apq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .rd_data (rd_data),
    .req     (req),
    .res     (res),
    .busy    (busy)
  );

  apq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status       <= res.status;
      out_value    <= res.value;
      out_priority <= res.prio;
    end
  end

endmodule
